// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the next prime finder.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/npf_pkg.sv =====
// Package for the next prime finder: widths, sequencer states and the
// status bundle of the shared remainder unit. No dependencies.
package npf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_WIDTH        = 32;
    localparam int OUT_WIDTH       = 31;

    // Trial divisors run 5, 11, 17, ... and each step also tries d + 2.
    localparam int FIRST_DIVISOR = 5;
    localparam int DIVISOR_STEP  = 6;
    localparam int PAIR_OFFSET   = 2;
    localparam int SMALL_PRIME   = 3;
    localparam int LOWEST_PRIME  = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_MOD3,
        ST_SQ,
        ST_MODA,
        ST_MODB,
        ST_NEXT,
        ST_FINISH
    } npf_state_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } npf_div_status_t;

endpackage

// ===== hw/rtl/npf_mod.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on npf_pkg for the status bundle.
module npf_mod #(
    parameter int DW = npf_pkg::VALUE_WIDTH_DEF - 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DW-1:0]            dividend,
    input  logic [DW-1:0]            divisor,
    output npf_pkg::npf_div_status_t status
);
    import npf_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dvd_reg, dvd_next;
    logic [DW-1:0]    dsr_reg, dsr_next;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (busy_reg) begin
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

    `include "assert_macros.svh"

    `NPF_ASSERT_IMP(a_done_idle, done_reg, !busy_reg, "remainder done while still busy")
    `NPF_ASSERT_NXT(a_start_busy, start && !busy_reg, busy_reg && cnt_reg == CNT_W'(DW),
        "start did not launch a full pass")

endmodule

// ===== hw/rtl/next_prime_finder.sv =====
// Starts below two or at the top go straight to the finish state. Otherwise an even
// candidate is skipped; an odd one first takes its remainder by three, then its remainders
// by each trial divisor pair (about sqrt(c)/6 pairs), then finishes or moves on.
// Throughput: one beat at a time; all remainders go through the one iterative unit.
// A new start beat is taken while a finished result waits on the output register.
// Reset: synchronous, active low aresetn; clears sequencer state and output valid.
module next_prime_finder #(
    parameter int VALUE_WIDTH = npf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [npf_pkg::IN_WIDTH-1:0]   s_start_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [npf_pkg::OUT_WIDTH-1:0]  m_next_prime,
    output logic                           m_overflow
);
    import npf_pkg::*;

    localparam int CW   = VALUE_WIDTH - 1;
    localparam int SQ_W = VALUE_WIDTH + 1;

    npf_state_t          state_reg, state_next;
    logic [CW-1:0]       c_reg, c_next;
    logic [CW-1:0]       d_reg, d_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [OUT_WIDTH-1:0] res_reg, res_next;
    logic                res_ovf_reg, res_ovf_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_WIDTH-1:0] prime_reg, prime_next;
    logic                ovf_reg, ovf_next;

    logic [VALUE_WIDTH-1:0] raw;
    logic                   raw_small;
    logic                   raw_top;
    logic                   sq_over;
    logic                   c_is_top;
    logic                   out_free;
    logic [SQ_W-1:0]        sq_step;

    logic                   div_start;
    logic [CW-1:0]          div_divisor;
    npf_div_status_t        div_status;

    assign raw       = s_start_value[VALUE_WIDTH-1:0];
    assign raw_small = raw[VALUE_WIDTH-1] || (raw[CW-1:0] < CW'(LOWEST_PRIME));
    assign raw_top   = (raw[CW-1:0] == {CW{1'b1}});
    assign sq_over   = sq_reg > SQ_W'(c_reg);
    assign c_is_top  = (c_reg == {CW{1'b1}});
    assign out_free  = !m_valid_reg || m_ready;
    // (d + 6)^2 = d^2 + 12d + 36
    assign sq_step   = (SQ_W'(d_reg) << 3) + (SQ_W'(d_reg) << 2)
                     + SQ_W'(DIVISOR_STEP * DIVISOR_STEP);

    npf_mod #(
        .DW(CW)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (c_reg),
        .divisor  (div_divisor),
        .status   (div_status)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (raw_small || raw_top) ? ST_FINISH : ST_CAND;
                end
            end
            ST_CAND: begin
                if (c_reg <= CW'(SMALL_PRIME)) begin
                    state_next = ST_FINISH;
                end else if (!c_reg[0]) begin
                    state_next = ST_NEXT;
                end else begin
                    state_next = ST_MOD3;
                end
            end
            ST_MOD3: begin
                if (div_status.done) begin
                    state_next = div_status.rem_zero ? ST_NEXT : ST_SQ;
                end
            end
            ST_SQ: begin
                state_next = sq_over ? ST_FINISH : ST_MODA;
            end
            ST_MODA: begin
                if (div_status.done) begin
                    state_next = div_status.rem_zero ? ST_NEXT : ST_MODB;
                end
            end
            ST_MODB: begin
                if (div_status.done) begin
                    state_next = div_status.rem_zero ? ST_NEXT : ST_SQ;
                end
            end
            ST_NEXT: begin
                state_next = c_is_top ? ST_FINISH : ST_CAND;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        c_next       = c_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        res_next     = res_reg;
        res_ovf_next = res_ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        prime_next   = prime_reg;
        ovf_next     = ovf_reg;
        div_start    = 1'b0;
        div_divisor  = d_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                c_next  = raw[CW-1:0] + CW'(1);
                if (raw_small) begin
                    res_next     = OUT_WIDTH'(LOWEST_PRIME);
                    res_ovf_next = 1'b0;
                end else if (raw_top) begin
                    res_next     = '0;
                    res_ovf_next = 1'b1;
                end
            end
            ST_CAND: begin
                res_next     = OUT_WIDTH'(c_reg);
                res_ovf_next = 1'b0;
                div_divisor  = CW'(SMALL_PRIME);
                div_start    = (c_reg > CW'(SMALL_PRIME)) && c_reg[0];
            end
            ST_MOD3: begin
                d_next  = CW'(FIRST_DIVISOR);
                sq_next = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
            end
            ST_SQ: begin
                div_divisor = d_reg;
                div_start   = !sq_over;
            end
            ST_MODA: begin
                div_divisor = d_reg + CW'(PAIR_OFFSET);
                div_start   = div_status.done && !div_status.rem_zero;
            end
            ST_MODB: begin
                if (div_status.done) begin
                    d_next  = d_reg + CW'(DIVISOR_STEP);
                    sq_next = sq_reg + sq_step;
                end
            end
            ST_NEXT: begin
                c_next = c_reg + CW'(1);
                if (c_is_top) begin
                    res_next     = '0;
                    res_ovf_next = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    prime_next   = res_reg;
                    ovf_next     = res_ovf_reg;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        c_reg       <= c_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        res_reg     <= res_next;
        res_ovf_reg <= res_ovf_next;
        prime_reg   <= prime_next;
        ovf_reg     <= ovf_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_next_prime = prime_reg;
    assign m_overflow   = ovf_reg;

    `include "assert_macros.svh"

    `NPF_ASSERT_IMP(a_start_free, div_start, !div_status.busy,
        "remainder unit started while busy")
    `NPF_ASSERT_IMP(a_ovf_zero, m_valid_reg && ovf_reg, prime_reg == '0,
        "overflow beat carries a nonzero prime")
    `NPF_ASSERT_IMP(a_prime_min, m_valid_reg && !ovf_reg, prime_reg >= OUT_WIDTH'(LOWEST_PRIME),
        "result beat below the lowest prime")
    `NPF_ASSERT_NXT(a_finish_load, state_reg == ST_FINISH && out_free, m_valid_reg,
        "finished result was not loaded")

endmodule
